// ----- rtl/core/trbd_pkg.sv -----
package trbd_pkg;

	// Address field width is fixed by the result format
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned DEF_ADDR_BYTES = 6;
	localparam logic [7:0] DEF_TAG_VALUE = 8'd71;

	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_ADDR    = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SKIP    = 3'd5
	} phase_t;

	typedef struct packed {
		logic [ADDR_W-1:0] source_address;
		logic [7:0]        subtype;
		logic [7:0]        body_byte;
		logic              byte_present;
		logic              record_last;
		logic              truncated;
	} result_t;

	// Parser to output register: one result candidate per beat
	typedef struct packed {
		logic    emit;
		result_t res;
	} result_beat_t;

endpackage

// ----- rtl/core/trbd_parser.sv -----
module trbd_parser #(
	parameter int unsigned ADDR_BYTES = trbd_pkg::DEF_ADDR_BYTES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              rx_byte,
	input  logic                    batch_end,
	input  logic [7:0]              tag_value,
	output trbd_pkg::result_beat_t  beat
);

	localparam int unsigned IDX_W = $clog2(ADDR_BYTES + 1);

	trbd_pkg::phase_t phase_q, phase_d;
	logic [7:0]                    left_q, left_d;
	logic [trbd_pkg::ADDR_W-1:0]   addr_q, addr_d;
	logic [IDX_W-1:0]              idx_q, idx_d;
	logic [15:0]                   len_q, len_d;
	logic [15:0]                   pos_q, pos_d;
	logic                          passes_q, passes_d;
	logic [7:0]                    sub_q, sub_d;

	logic [16:0] pos_inc;
	logic        last;
	logic [7:0]  left_dec;
	logic [15:0] len_full;

	assign pos_inc  = {1'b0, pos_q} + 17'd1;
	assign last     = pos_inc >= {1'b0, len_q};
	assign left_dec = left_q - 8'd1;
	assign len_full = {rx_byte, len_q[7:0]};

	// next state
	always_comb begin
		logic clear_hdr;
		logic finish;
		clear_hdr = 1'b0;
		finish    = 1'b0;
		phase_d   = phase_q;
		left_d    = left_q;
		addr_d    = addr_q;
		idx_d     = idx_q;
		len_d     = len_q;
		pos_d     = pos_q;
		passes_d  = passes_q;
		sub_d     = sub_q;
		unique case (phase_q)
			trbd_pkg::PH_COUNT: begin
				left_d    = rx_byte;
				clear_hdr = 1'b1;
				phase_d   = (rx_byte == 8'd0) ? trbd_pkg::PH_SKIP : trbd_pkg::PH_ADDR;
			end
			trbd_pkg::PH_ADDR: begin
				addr_d = {addr_q[trbd_pkg::ADDR_W-9:0], rx_byte};
				idx_d  = idx_q + IDX_W'(1);
				if (idx_d >= IDX_W'(ADDR_BYTES)) begin
					phase_d = trbd_pkg::PH_LEN_LO;
				end
			end
			trbd_pkg::PH_LEN_LO: begin
				len_d   = {8'd0, rx_byte};
				phase_d = trbd_pkg::PH_LEN_HI;
			end
			trbd_pkg::PH_LEN_HI: begin
				len_d = len_full;
				pos_d = 16'd0;
				if (len_full == 16'd0) begin
					finish = 1'b1;
				end else begin
					phase_d = trbd_pkg::PH_PAYLOAD;
				end
			end
			trbd_pkg::PH_PAYLOAD: begin
				if (pos_q == 16'd0) begin
					passes_d = (len_q >= 16'd2) && (rx_byte == tag_value);
				end else if (pos_q == 16'd1) begin
					sub_d = rx_byte;
				end
				pos_d = pos_inc[15:0];
				if (last) begin
					finish = 1'b1;
				end
			end
			trbd_pkg::PH_SKIP: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = trbd_pkg::PH_COUNT;
			end
		endcase
		if (finish) begin
			left_d    = left_dec;
			clear_hdr = 1'b1;
			phase_d   = (left_dec == 8'd0) ? trbd_pkg::PH_SKIP : trbd_pkg::PH_ADDR;
		end
		if (batch_end) begin
			phase_d   = trbd_pkg::PH_COUNT;
			left_d    = 8'd0;
			clear_hdr = 1'b1;
		end
		if (clear_hdr) begin
			addr_d   = '0;
			idx_d    = '0;
			len_d    = 16'd0;
			pos_d    = 16'd0;
			passes_d = 1'b0;
			sub_d    = 8'd0;
		end
	end

	// result candidate
	always_comb begin
		logic trunc;
		trunc = batch_end && !last;
		beat.emit                    = 1'b0;
		beat.res.source_address      = addr_q;
		beat.res.subtype             = (pos_q == 16'd1) ? rx_byte : sub_q;
		beat.res.body_byte           = 8'd0;
		beat.res.byte_present        = 1'b0;
		beat.res.record_last         = 1'b0;
		beat.res.truncated           = 1'b0;
		if ((phase_q == trbd_pkg::PH_PAYLOAD) && passes_q) begin
			if (pos_q == 16'd1) begin
				beat.emit            = last;
				beat.res.record_last = 1'b1;
			end else if (pos_q >= 16'd2) begin
				beat.emit              = 1'b1;
				beat.res.body_byte     = rx_byte;
				beat.res.byte_present  = 1'b1;
				beat.res.record_last   = last || trunc;
				beat.res.truncated     = trunc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= trbd_pkg::PH_COUNT;
			left_q   <= 8'd0;
			addr_q   <= '0;
			idx_q    <= '0;
			len_q    <= 16'd0;
			pos_q    <= 16'd0;
			passes_q <= 1'b0;
			sub_q    <= 8'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			addr_q   <= addr_d;
			idx_q    <= idx_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
			passes_q <= passes_d;
			sub_q    <= sub_d;
		end
	end

endmodule

// ----- rtl/core/trbd_out_reg.sv -----
module trbd_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  trbd_pkg::result_beat_t beat,
	input  logic                   out_stall,
	output logic                   ready,
	output logic                   out_valid,
	output trbd_pkg::result_t      res
);

	logic              valid_q;
	trbd_pkg::result_t res_q;
	logic              load;

	assign ready     = !valid_q || !out_stall;
	assign load      = take && beat.emit;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= beat.res;
		end
	end

endmodule

// ----- rtl/core/tagged_record_batch_deframer.sv -----
// channel | direction | handshake              | payload
// in      | in        | in_valid / in_stall    | rx_byte, batch_end
// out     | out       | out_valid / out_stall  | source_address, subtype, body_byte,
//         |           |                        | byte_present, record_last, truncated
// cfg     | in        | cfg_wen                | cfg_wdata (tag_value)
//
// One input beat per cycle while in_stall is low; a result appears in the cycle after the
// beat that causes it is taken, held in one result register that the parser state registers feed.
// Reset (arst_n low) puts the parser in the count-byte phase and tag_value at 'G'.
// in_stall rises only while a held result is stalled on the output side.
// cfg_wen writes tag_value at once, no wait.
module tagged_record_batch_deframer #(
	parameter int unsigned ADDR_BYTES = trbd_pkg::DEF_ADDR_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	input  logic                        batch_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [trbd_pkg::ADDR_W-1:0] source_address,
	output logic [7:0]                  subtype,
	output logic [7:0]                  body_byte,
	output logic                        byte_present,
	output logic                        record_last,
	output logic                        truncated,
	input  logic                        cfg_wen,
	input  logic [7:0]                  cfg_wdata
);

	logic [7:0]             tag_value_q;
	logic                   ready;
	logic                   take;
	trbd_pkg::result_beat_t beat;
	trbd_pkg::result_t      res;

	// tag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_value_q <= trbd_pkg::DEF_TAG_VALUE;
		end else if (cfg_wen) begin
			tag_value_q <= cfg_wdata;
		end
	end

	// a beat is taken whenever the result register is free or draining
	assign in_stall = !ready;
	assign take     = in_valid && ready;

	trbd_parser #(
		.ADDR_BYTES (ADDR_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.batch_end (batch_end),
		.tag_value (tag_value_q),
		.beat      (beat)
	);

	trbd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.beat      (beat),
		.out_stall (out_stall),
		.ready     (ready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign source_address = res.source_address;
	assign subtype        = res.subtype;
	assign body_byte      = res.body_byte;
	assign byte_present   = res.byte_present;
	assign record_last    = res.record_last;
	assign truncated      = res.truncated;

	// a truncated beat always closes its record
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> record_last)
		else $error("truncated beat without record_last");

	// empty-body result is a clean record end with no byte
	a_empty_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present |-> record_last && !truncated && body_byte == 8'd0)
		else $error("empty-body result malformed");

	// input is held back only by a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a new result always follows an accepted beat
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without input beat");

endmodule
